/* src/fdp_pkg.sv */
// Shared types and constants for the FIFO demand paging unit.
`default_nettype none
package fdp_pkg;

	// Page table and FIFO geometry
	localparam int MaxSlots = 4;
	localparam int SlotW    = $clog2(MaxSlots);
	localparam int CountW   = $clog2(MaxSlots + 1);
	localparam int MaxPages = 16;
	localparam int PageW    = $clog2(MaxPages);
	localparam int MaxTasks = 8;
	localparam int TaskW    = $clog2(MaxTasks);
	localparam int FrameW   = 6;
	localparam int FaultW   = 16;

	// Configuration register widths and reset values
	localparam int FptW  = 3;
	localparam int OsW   = 5;
	localparam int CfgW  = 5;
	localparam logic [FptW-1:0] FptReset = 3'd3;
	localparam logic [OsW-1:0]  OsReset  = 5'd2;

	localparam logic [FaultW-1:0] FaultMax = '1;

	// Commands carried in the input tuser
	typedef enum logic [0:0] {
		CMD_REF       = 1'b0,
		CMD_NEXT_TASK = 1'b1
	} cmd_t;

	// Configuration register indexes
	typedef enum logic [0:0] {
		CFG_FRAMES_PER_TASK = 1'b0,
		CFG_OS_FRAMES       = 1'b1
	} cfg_idx_t;

	// One accepted request
	typedef struct packed {
		cmd_t             command;
		logic [PageW-1:0] page_number;
	} req_t;

	// One result item
	typedef struct packed {
		logic [FaultW-1:0] fault_total;
		logic [PageW-1:0]  evicted_page;
		logic              evicted_valid;
		logic [FrameW-1:0] frame_number;
		logic              fault;
	} res_t;

endpackage
`default_nettype wire

/* src/fifo_demand_paging_unit.sv */
// Top level of the FIFO demand paging unit.
//
//  Channel  Direction  Contents
//  s_*      in         tuser[0] command; tdata[3:0] page_number, [7:4] zero
//  m_*      out        tdata[0] fault, [6:1] frame_number, [7] evicted_valid,
//                      [11:8] evicted_page, [27:12] fault_total, [31:28] zero
//  cfg_*    in         index 0 frames_per_task, index 1 os_frames
//
// One request per cycle sustained while m_tready stays high. An s transfer reaches m_tvalid
// through the input register and then the result register; the page lookup between the two
// is combinational, and the FIFO state updates as the result register loads.
// Reset clears the page table, FIFO, task index and fault count; no clearing pass.
// A stalled m side holds its result while one more request waits in the input register.
`default_nettype none
module fifo_demand_paging_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [3:0] page_number
	input  wire  [0:0]  s_tuser,   // [0] command
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // fault, frame_number, evicted_valid, evicted_page, fault_total
	input  wire         cfg_we,
	input  wire  [0:0]  cfg_index,
	input  wire  [4:0]  cfg_data
);

	fdp_pkg::req_t in_req;
	fdp_pkg::req_t req;
	fdp_pkg::res_t res;
	fdp_pkg::res_t out_res;
	logic          req_valid;
	logic          fire;

	// Unpack the input transfer
	always_comb begin
		in_req.command     = fdp_pkg::cmd_t'(s_tuser[0]);
		in_req.page_number = s_tdata[fdp_pkg::PageW-1:0];
	end

	fdp_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_req    (in_req),
		.req_valid (req_valid),
		.req       (req),
		.req_take  (fire)
	);

	fdp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (fdp_pkg::cfg_idx_t'(cfg_index)),
		.cfg_data  (cfg_data),
		.fire      (fire),
		.req       (req),
		.res       (res)
	);

	fdp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (req_valid),
		.res_take  (fire),
		.res       (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// Pack the result, zero filled to 32 bits
	assign m_tdata = {4'b0, out_res};

endmodule
`default_nettype wire

/* src/fdp_in_stage.sv */
// Input register stage: captures one request per transfer.
`default_nettype none
module fdp_in_stage (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  fdp_pkg::req_t    in_req,
	output logic             req_valid,
	output fdp_pkg::req_t    req,
	input  wire              req_take
);

	logic          valid_s1;
	fdp_pkg::req_t req_s1;

	// Free when empty or when the held request moves on this cycle
	assign in_ready  = !valid_s1 || req_take;
	assign req_valid = valid_s1;
	assign req       = req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_req;
		end
	end

endmodule
`default_nettype wire

/* src/fdp_core.sv */
// Page table, FIFO replacement state and frame computation.
`default_nettype none
module fdp_core (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_we,
	input  fdp_pkg::cfg_idx_t         cfg_index,
	input  wire [fdp_pkg::CfgW-1:0]   cfg_data,
	input  wire                       fire,
	input  fdp_pkg::req_t             req,
	output fdp_pkg::res_t             res
);

	// Configuration registers
	logic [fdp_pkg::FptW-1:0] fpt_q;
	logic [fdp_pkg::OsW-1:0]  os_q;

	// Paging state
	logic [fdp_pkg::MaxPages-1:0] page_loaded_q;
	logic [fdp_pkg::SlotW-1:0]    page_slot_q  [fdp_pkg::MaxPages];
	logic [fdp_pkg::PageW-1:0]    fifo_pages_q [fdp_pkg::MaxSlots];
	logic [fdp_pkg::SlotW-1:0]    fifo_slots_q [fdp_pkg::MaxSlots];
	logic [fdp_pkg::SlotW-1:0]    fifo_head_q;
	logic [fdp_pkg::CountW-1:0]   fifo_count_q;
	logic [fdp_pkg::TaskW-1:0]    task_q;
	logic [fdp_pkg::FaultW-1:0]   fault_cnt_q;

	logic                         is_ref;
	logic                         hit;
	logic                         miss;
	logic                         evict;
	logic [fdp_pkg::FptW-1:0]     eff;
	logic [fdp_pkg::SlotW-1:0]    slot;
	logic [fdp_pkg::SlotW-1:0]    head_n;
	logic [fdp_pkg::CountW-1:0]   count_mid;
	logic [fdp_pkg::SlotW-1:0]    tail;
	logic [fdp_pkg::FaultW-1:0]   fault_cnt_n;
	logic [fdp_pkg::TaskW+fdp_pkg::FptW-1:0] task_off;
	logic [fdp_pkg::FrameW+1:0]   frame_sum;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fpt_q <= fdp_pkg::FptReset;
			os_q  <= fdp_pkg::OsReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fdp_pkg::CFG_FRAMES_PER_TASK: fpt_q <= cfg_data[fdp_pkg::FptW-1:0];
				fdp_pkg::CFG_OS_FRAMES:       os_q  <= cfg_data[fdp_pkg::OsW-1:0];
				default: ;
			endcase
		end
	end

	// Lookup, replacement choice and frame address
	always_comb begin
		if (fpt_q == '0) begin
			eff = fdp_pkg::FptW'(1);
		end else if (fpt_q > fdp_pkg::FptW'(fdp_pkg::MaxSlots)) begin
			eff = fdp_pkg::FptW'(fdp_pkg::MaxSlots);
		end else begin
			eff = fpt_q;
		end

		is_ref = (req.command == fdp_pkg::CMD_REF);
		hit    = page_loaded_q[req.page_number];
		miss   = is_ref && !hit;
		evict  = miss && (fdp_pkg::FptW'(fifo_count_q) >= eff);

		// The FIFO entry keeps the evicted page's slot
		if (hit) begin
			slot = page_slot_q[req.page_number];
		end else if (evict) begin
			slot = fifo_slots_q[fifo_head_q];
		end else begin
			slot = fifo_count_q[fdp_pkg::SlotW-1:0];
		end

		head_n    = evict ? fifo_head_q + 1'b1 : fifo_head_q;
		count_mid = evict ? fifo_count_q - 1'b1 : fifo_count_q;
		tail      = head_n + count_mid[fdp_pkg::SlotW-1:0];

		fault_cnt_n = (miss && fault_cnt_q != fdp_pkg::FaultMax) ?
			fault_cnt_q + 1'b1 : fault_cnt_q;

		task_off  = task_q * eff;
		frame_sum = (fdp_pkg::FrameW+2)'(os_q) + (fdp_pkg::FrameW+2)'(task_off)
			+ (fdp_pkg::FrameW+2)'(slot);

		res.fault         = miss;
		res.frame_number  = is_ref ? frame_sum[fdp_pkg::FrameW-1:0] : '0;
		res.evicted_valid = evict;
		res.evicted_page  = evict ? fifo_pages_q[fifo_head_q] : '0;
		res.fault_total   = fault_cnt_n;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_loaded_q <= '0;
			fifo_head_q   <= '0;
			fifo_count_q  <= '0;
			task_q        <= '0;
			fault_cnt_q   <= '0;
		end else if (fire) begin
			if (!is_ref) begin
				page_loaded_q <= '0;
				fifo_head_q   <= '0;
				fifo_count_q  <= '0;
				task_q        <= task_q + 1'b1;
			end else if (miss) begin
				fault_cnt_q   <= fault_cnt_n;
				fifo_head_q   <= head_n;
				fifo_count_q  <= count_mid + 1'b1;
				if (evict) begin
					page_loaded_q[fifo_pages_q[fifo_head_q]] <= 1'b0;
				end
				page_loaded_q[req.page_number] <= 1'b1;
			end
		end
	end

	// Payload stores, written on a fault
	always_ff @(posedge clk) begin
		if (fire && miss) begin
			page_slot_q[req.page_number] <= slot;
			fifo_pages_q[tail]           <= req.page_number;
			fifo_slots_q[tail]           <= slot;
		end
	end

	// Every loaded page sits in the FIFO exactly once
	a_loaded_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		fdp_pkg::CountW'($countones(page_loaded_q)) == fifo_count_q)
		else $error("loaded page count differs from FIFO occupancy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count_q <= fdp_pkg::CountW'(fdp_pkg::MaxSlots))
		else $error("FIFO occupancy above slot count");

	a_switch_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !is_ref |=> fifo_count_q == '0 && page_loaded_q == '0)
		else $error("task switch left pages loaded");

	a_fault_loads: assert property (@(posedge clk) disable iff (!arst_n)
		fire && miss |=> page_loaded_q[$past(req.page_number)])
		else $error("faulted page not marked loaded");

endmodule
`default_nettype wire

/* src/fdp_out_stage.sv */
// Result register: holds one result until the downstream transfer.
`default_nettype none
module fdp_out_stage (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              res_valid,
	output logic             res_take,
	input  fdp_pkg::res_t    res,
	output logic             out_valid,
	input  wire              out_ready,
	output fdp_pkg::res_t    out_res
);

	logic          valid_q;
	fdp_pkg::res_t res_q;

	// Load when empty or when the held result leaves this cycle
	assign res_take  = res_valid && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

/* verif/tb_fifo_demand_paging_unit.sv */
// Self-checking testbench for the FIFO demand paging unit.
`default_nettype none
module tb_fifo_demand_paging_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import fdp_pkg::*;

	localparam int CycleLimit = 20_000;
	localparam int GapPct     = 23;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata = '0;
	logic [0:0]        s_tuser = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [31:0]       m_tdata;
	logic              cfg_we = 1'b0;
	logic [0:0]        cfg_index = '0;
	logic [CfgW-1:0]   cfg_data = '0;

	fifo_demand_paging_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [3:0] page_number, [7:4] zero
		.s_tuser   (s_tuser),   // [0] command
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // fault, frame_number, evicted_valid, evicted_page, fault_total
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow copy of the paging state
	logic [FptW-1:0]   fpt_reg = FptReset;
	logic [OsW-1:0]    os_reg  = OsReset;
	logic              loaded [MaxPages] = '{default: 1'b0};
	logic [SlotW-1:0]  slot_of [MaxPages] = '{default: '0};
	logic [PageW-1:0]  resident [MaxSlots] = '{default: '0};
	logic [SlotW-1:0]  head = '0;
	int                occupancy = 0;
	logic [TaskW-1:0]  task_no = '0;
	logic [FaultW-1:0] fault_cnt = '0;

	res_t expected_results[$];
	int   mismatches = 0;
	int   cycle_cnt = 0;
	bit   gaps_on = 1'b1;

	// Directed stimulus rows: either a register setting or one request
	typedef struct {
		bit               is_cfg;
		logic [FptW-1:0]  fpt;
		logic [OsW-1:0]   os;
		cmd_t             cmd;
		logic [PageW-1:0] page;
		bit               typed;
		res_t             want;
	} plan_row_t;

	plan_row_t plan[$];

	// Advance the shadow state by one request and return its result
	function automatic res_t predict_reference(cmd_t cmd, logic [PageW-1:0] page);
		res_t             r;
		int               eff;
		int               slot;
		logic [PageW-1:0] victim;
		r = '0;
		slot = 0;
		eff = (fpt_reg == 0) ? 1 : ((int'(fpt_reg) > MaxSlots) ? MaxSlots : int'(fpt_reg));
		if (cmd == CMD_NEXT_TASK) begin
			loaded = '{default: 1'b0};
			head = '0;
			occupancy = 0;
			task_no = task_no + 1'b1;
		end else if (loaded[page]) begin
			slot = slot_of[page];
		end else begin
			r.fault = 1'b1;
			if (fault_cnt != FaultMax)
				fault_cnt = fault_cnt + 1'b1;
			// full (or over-full after lowering the limit): replace the oldest page
			if (occupancy >= eff) begin
				victim = resident[head];
				r.evicted_valid = 1'b1;
				r.evicted_page = victim;
				slot = slot_of[victim];
				loaded[victim] = 1'b0;
				head = head + 1'b1;
				occupancy--;
			end else begin
				slot = occupancy;
			end
			resident[SlotW'(int'(head) + occupancy)] = page;
			occupancy++;
			loaded[page] = 1'b1;
			slot_of[page] = SlotW'(slot);
		end
		if (cmd == CMD_REF)
			r.frame_number = FrameW'(int'(os_reg) + int'(task_no) * eff + slot);
		r.fault_total = fault_cnt;
		return r;
	endfunction

	function automatic res_t mk_res(bit f, int frame, bit ev, int ev_page, int total);
		res_t r;
		r.fault = f;
		r.frame_number = FrameW'(frame);
		r.evicted_valid = ev;
		r.evicted_page = PageW'(ev_page);
		r.fault_total = FaultW'(total);
		return r;
	endfunction

	function automatic void plan_add(cmd_t cmd, int page, bit typed = 1'b0, res_t want = '0);
		plan_row_t row;
		row = '{is_cfg: 1'b0, fpt: '0, os: '0, cmd: cmd, page: PageW'(page),
			typed: typed, want: want};
		plan.push_back(row);
	endfunction

	function automatic void plan_cfg(int fpt, int os);
		plan_row_t row;
		row = '{is_cfg: 1'b1, fpt: FptW'(fpt), os: OsW'(os), cmd: CMD_REF, page: '0,
			typed: 1'b0, want: '0};
		plan.push_back(row);
	endfunction

	// Write both registers back to back once no result is outstanding
	task automatic configure(logic [FptW-1:0] fpt, logic [OsW-1:0] os);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FRAMES_PER_TASK;
		cfg_data <= CfgW'(fpt);
		@(posedge clk);
		cfg_index <= CFG_OS_FRAMES;
		cfg_data <= CfgW'(os);
		@(posedge clk);
		cfg_we <= 1'b0;
		fpt_reg = fpt;
		os_reg = os;
	endtask

	// One request transfer, with random idle cycles in front while gaps are on, each drawn on its own
	task automatic issue_request(cmd_t cmd, logic [PageW-1:0] page, bit typed, res_t want);
		res_t model;
		if (gaps_on) begin
			while ($urandom_range(0, 99) < GapPct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {{(8 - PageW){1'b0}}, page};
		do
			@(posedge clk);
		while (!s_tready);
		model = predict_reference(cmd, page);
		expected_results.push_back(typed ? want : model);
	endtask

	// Result side back-pressure
	always @(posedge clk) begin
		m_tready <= !gaps_on || ($urandom_range(0, 99) >= GapPct);
	end

	// Result checker
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = res_t'(m_tdata[$bits(res_t)-1:0]);
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: ",
						"fault=%0d frame=%0d ev=%0d/%0d total=%0d",
						got.fault, got.frame_number, got.evicted_valid, got.evicted_page,
						got.fault_total);
			end else begin
				want = expected_results.pop_front();
				if (got.fault !== want.fault || got.frame_number !== want.frame_number ||
						got.evicted_valid !== want.evicted_valid ||
						got.evicted_page !== want.evicted_page ||
						got.fault_total !== want.fault_total) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp fault=%0d frame=%0d ev=%0d/%0d total=%0d, ",
							want.fault, want.frame_number, want.evicted_valid,
							want.evicted_page, want.fault_total,
							"got fault=%0d frame=%0d ev=%0d/%0d total=%0d",
							got.fault, got.frame_number, got.evicted_valid,
							got.evicted_page, got.fault_total);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [PageW-1:0] page;
		logic [PageW-1:0] ws_base;
		int               ws_size;
		logic [FptW-1:0]  fpt;
		logic [OsW-1:0]   os;

		// Directed part: reset defaults are 3 frames per task after 2 OS frames
		plan_add(CMD_REF, 0, 1'b1, mk_res(1'b1, 2, 1'b0, 0, 1));
		plan_add(CMD_REF, 15, 1'b1, mk_res(1'b1, 3, 1'b0, 0, 2));
		plan_add(CMD_REF, 0, 1'b1, mk_res(1'b0, 2, 1'b0, 0, 2));
		plan_add(CMD_REF, 7, 1'b1, mk_res(1'b1, 4, 1'b0, 0, 3));
		plan_add(CMD_REF, 9, 1'b1, mk_res(1'b1, 2, 1'b1, 0, 4));
		plan_add(CMD_REF, 15, 1'b1, mk_res(1'b0, 3, 1'b0, 0, 4));
		plan_add(CMD_NEXT_TASK, 0, 1'b1, mk_res(1'b0, 0, 1'b0, 0, 4));
		// zero frames per task acts as one
		plan_cfg(0, 31);
		plan_add(CMD_REF, 5, 1'b1, mk_res(1'b1, 32, 1'b0, 0, 5));
		plan_add(CMD_REF, 10, 1'b1, mk_res(1'b1, 32, 1'b1, 5, 6));
		// oversized setting saturates to four slots
		plan_cfg(7, 31);
		plan_add(CMD_REF, 1);
		plan_add(CMD_REF, 2);
		plan_add(CMD_REF, 3);
		plan_add(CMD_REF, 4);
		// lowered limit with a full FIFO: occupancy holds
		plan_cfg(1, 31);
		plan_add(CMD_REF, 6);
		plan_add(CMD_REF, 14);
		repeat (6)
			plan_add(CMD_NEXT_TASK, 0);
		// last task at the top of the frame space
		plan_cfg(4, 31);
		plan_add(CMD_REF, 3);
		plan_add(CMD_REF, 8);
		plan_add(CMD_REF, 12);
		plan_add(CMD_REF, 13);
		// task index wraps back to zero
		plan_add(CMD_NEXT_TASK, 15);
		plan_cfg(4, 0);
		plan_add(CMD_REF, 0);

		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				configure(plan[i].fpt, plan[i].os);
			else
				issue_request(plan[i].cmd, plan[i].page, plan[i].typed, plan[i].want);
		end

		// Random part: working sets per phase, occasional task switches and stray pages
		for (int phase = 0; phase < 8; phase++) begin
			unique case (phase)
				0: begin
					fpt = 3'd1;
					os = '0;
				end
				1: begin
					fpt = 3'd4;
					os = '1;
				end
				default: begin
					fpt = FptW'($urandom_range(0, 7));
					os = OsW'($urandom_range(0, 31));
				end
			endcase
			configure(fpt, os);
			gaps_on = (phase != 3);
			ws_size = $urandom_range(2, 8);
			ws_base = PageW'($urandom_range(0, MaxPages - 1));
			for (int n = 0; n < 42; n++) begin
				if ($urandom_range(0, 99) < 6) begin
					issue_request(CMD_NEXT_TASK, PageW'($urandom_range(0, MaxPages - 1)),
						1'b0, '0);
				end else begin
					if ($urandom_range(0, 99) < 15)
						page = PageW'($urandom_range(0, MaxPages - 1));
					else
						page = ws_base + PageW'($urandom_range(0, ws_size - 1));
					issue_request(CMD_REF, page, 1'b0, '0);
				end
			end
		end

		// Long stretch without idling: one frame per task, so every reference faults and each after the first evicts
		gaps_on = 1'b0;
		configure(3'd1, OsW'($urandom_range(0, 31)));
		issue_request(CMD_NEXT_TASK, '0, 1'b0, '0);
		page = '0;
		for (int n = 0; n < 24; n++) begin
			page = page ^ PageW'($urandom_range(1, MaxPages - 1));
			issue_request(CMD_REF, page, 1'b0, '0);
		end
		gaps_on = 1'b1;
		for (int n = 0; n < 20; n++) begin
			page = page ^ PageW'($urandom_range(0, MaxPages - 1));
			issue_request((n == 10) ? CMD_NEXT_TASK : CMD_REF, page, 1'b0, '0);
		end

		// Drain outstanding results, then allow for the pipeline latency
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
